// ----- sv/aeq_pkg.sv -----
// aeq_pkg: shared types and constants of the alarm event qualifier
// request and result payload structs, register indexes, reset values
// no dependencies
package aeq_pkg;

	localparam int unsigned NUM_CH  = 4;
	localparam int unsigned FIRE_CH = 3;

	// register indexes on the configuration port
	localparam logic [2:0] REG_DETECT_ENABLE     = 3'd0;
	localparam logic [2:0] REG_AUTO_WARN         = 3'd1;
	localparam logic [2:0] REG_TRIGGER_THRESHOLD = 3'd2;
	localparam logic [2:0] REG_FIRE_THRESHOLD    = 3'd3;
	localparam logic [2:0] REG_HOLDOFF_LIMIT     = 3'd4;
	localparam logic [2:0] REG_SIREN_HOLD_FRAMES = 3'd5;

	// register reset values
	localparam logic [7:0] RST_TRIGGER_THRESHOLD = 8'd5;
	localparam logic [7:0] RST_FIRE_THRESHOLD    = 8'd1;
	localparam logic [7:0] RST_HOLDOFF_LIMIT     = 8'd100;
	localparam logic [7:0] RST_SIREN_HOLD_FRAMES = 8'd65;

	localparam logic [7:0] CNT_MAX = 8'hFF;

	typedef struct packed {
		logic       frame_valid;
		logic [3:0] detect_flags;
		logic [3:0] window_open;
	} item_t;

	typedef struct packed {
		logic [3:0] report_bits;
		logic       siren_on;
		logic       siren_off;
		logic [3:0] latched_bits;
	} result_t;

endpackage

// ----- sv/alarm_event_qualifier_unit.sv -----
// alarm_event_qualifier_unit: per-frame qualification of four alarm channels
// a result is registered in the output register, or in the skid entry while the output is stalled
// throughput: one request per cycle while item_stall is low; a two-deep result buffer absorbs one stalled result
// reset: arst_n asynchronous active low clears all counters and latches,
// loads the register reset values and empties the result buffer
// depends on aeq_pkg
module alarm_event_qualifier_unit (
	input  logic                clk,
	input  logic                arst_n,
	// configuration write port
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [7:0]          cfg_wdata,
	// request channel, one request per video frame
	input  logic                item_valid,
	output logic                item_stall,
	input  aeq_pkg::item_t      item,
	// result channel
	output logic                result_valid,
	input  logic                result_stall,
	output aeq_pkg::result_t    result
);

	// configuration registers
	logic [3:0] det_en_q;
	logic [3:0] auto_warn_q;
	logic [7:0] trig_thr_q;
	logic [7:0] fire_thr_q;
	logic [7:0] holdoff_lim_q;
	logic [7:0] siren_hold_q;

	// channel and siren state
	logic [7:0] trig_cnt_q [aeq_pkg::NUM_CH];
	logic [7:0] hold_cnt_q [aeq_pkg::NUM_CH];
	logic [3:0] latched_q;
	logic [7:0] trig_total_q;
	logic [7:0] last_seen_q;
	logic [7:0] quiet_q;

	// result buffer: output register plus skid entry
	aeq_pkg::result_t res_q;
	aeq_pkg::result_t skd_q;
	logic             res_vld_q;
	logic             skd_vld_q;

	// next-state values
	logic [7:0] trig_cnt_d [aeq_pkg::NUM_CH];
	logic [7:0] hold_cnt_d [aeq_pkg::NUM_CH];
	logic [3:0] latched_d;
	logic [7:0] trig_total_d;
	logic [7:0] last_seen_d;
	logic [7:0] quiet_d;
	aeq_pkg::result_t res_d;

	logic accept;
	logic pop;

	function automatic logic [7:0] sat_inc(input logic [7:0] v);
		sat_inc = (v == aeq_pkg::CNT_MAX) ? aeq_pkg::CNT_MAX : v + 8'd1;
	endfunction

	assign accept     = item_valid && !item_stall;
	assign pop        = res_vld_q && !result_stall;
	// the skid entry is the only place left for a new result
	assign item_stall = skd_vld_q;

	assign result_valid = res_vld_q;
	assign result       = res_q;

	// ------------------------------------------------------------------
	// one frame of work, all from the current state and the request
	// ------------------------------------------------------------------
	always_comb begin
		logic [3:0] lat1;
		logic [7:0] hinc;
		logic [7:0] tt1;
		logic [7:0] cnt1;
		logic [7:0] thr;
		logic [2:0] warn_n;
		logic [8:0] tt_sum;
		logic [3:0] report;
		logic       on;
		logic       off;

		lat1        = latched_q;
		hinc        = '0;
		cnt1        = '0;
		thr         = '0;
		warn_n      = '0;
		report      = '0;
		on          = 1'b0;
		off         = 1'b0;
		tt1         = trig_total_q;
		last_seen_d = last_seen_q;
		quiet_d     = quiet_q;

		// hold-off aging: latched channels count frames until released
		for (int c = 0; c < aeq_pkg::NUM_CH; c++) begin
			hold_cnt_d[c] = hold_cnt_q[c];
			trig_cnt_d[c] = trig_cnt_q[c];
			if (latched_q[c]) begin
				hinc = sat_inc(hold_cnt_q[c]);
				if (hinc > holdoff_lim_q) begin
					lat1[c]       = 1'b0;
					hold_cnt_d[c] = '0;
				end else begin
					hold_cnt_d[c] = hinc;
				end
			end
		end

		// siren hold timer, idle while nothing has triggered
		if (trig_total_q != 8'd0) begin
			if (last_seen_q == trig_total_q) begin
				quiet_d = sat_inc(quiet_q);
			end else begin
				last_seen_d = trig_total_q;
				quiet_d     = '0;
			end
			if (quiet_d >= siren_hold_q) begin
				off         = 1'b1;
				tt1         = '0;
				last_seen_d = '0;
				quiet_d     = '0;
			end
		end

		// qualification on valid frames only
		latched_d = lat1;
		if (item.frame_valid) begin
			for (int c = 0; c < aeq_pkg::NUM_CH; c++) begin
				thr = (c == aeq_pkg::FIRE_CH) ? fire_thr_q : trig_thr_q;
				if (det_en_q[c] && item.window_open[c]) begin
					cnt1 = (item.detect_flags[c] && !lat1[c]) ?
						sat_inc(trig_cnt_q[c]) : trig_cnt_q[c];
					if (cnt1 > thr && !lat1[c]) begin
						report[c]     = 1'b1;
						latched_d[c]  = 1'b1;
						trig_cnt_d[c] = '0;
						if (auto_warn_q[c]) begin
							on     = 1'b1;
							warn_n = warn_n + 3'd1;
						end
					end else begin
						trig_cnt_d[c] = cnt1;
					end
				end else begin
					// channel out of play: count and latch dropped, hold-off kept
					trig_cnt_d[c] = '0;
					latched_d[c]  = 1'b0;
				end
			end
		end

		// at most four increments, so one saturating add covers them all
		tt_sum       = {1'b0, tt1} + {6'd0, warn_n};
		trig_total_d = tt_sum[8] ? aeq_pkg::CNT_MAX : tt_sum[7:0];

		res_d.report_bits  = report;
		res_d.siren_on     = on;
		res_d.siren_off    = off;
		res_d.latched_bits = latched_d;
	end

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			det_en_q      <= '0;
			auto_warn_q   <= '0;
			trig_thr_q    <= aeq_pkg::RST_TRIGGER_THRESHOLD;
			fire_thr_q    <= aeq_pkg::RST_FIRE_THRESHOLD;
			holdoff_lim_q <= aeq_pkg::RST_HOLDOFF_LIMIT;
			siren_hold_q  <= aeq_pkg::RST_SIREN_HOLD_FRAMES;
		end else if (cfg_we) begin
			case (cfg_index)
				aeq_pkg::REG_DETECT_ENABLE:     det_en_q      <= cfg_wdata[3:0];
				aeq_pkg::REG_AUTO_WARN:         auto_warn_q   <= cfg_wdata[3:0];
				aeq_pkg::REG_TRIGGER_THRESHOLD: trig_thr_q    <= cfg_wdata;
				aeq_pkg::REG_FIRE_THRESHOLD:    fire_thr_q    <= cfg_wdata;
				aeq_pkg::REG_HOLDOFF_LIMIT:     holdoff_lim_q <= cfg_wdata;
				aeq_pkg::REG_SIREN_HOLD_FRAMES: siren_hold_q  <= cfg_wdata;
				default: ; // unknown index, write dropped
			endcase
		end
	end

	// ------------------------------------------------------------------
	// channel and siren state, advanced once per accepted request
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < aeq_pkg::NUM_CH; c++) begin
				trig_cnt_q[c] <= '0;
				hold_cnt_q[c] <= '0;
			end
			latched_q    <= '0;
			trig_total_q <= '0;
			last_seen_q  <= '0;
			quiet_q      <= '0;
		end else if (accept) begin
			for (int c = 0; c < aeq_pkg::NUM_CH; c++) begin
				trig_cnt_q[c] <= trig_cnt_d[c];
				hold_cnt_q[c] <= hold_cnt_d[c];
			end
			latched_q    <= latched_d;
			trig_total_q <= trig_total_d;
			last_seen_q  <= last_seen_d;
			quiet_q      <= quiet_d;
		end
	end

	// ------------------------------------------------------------------
	// result buffer: skid entry fills only while the output is stalled
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
			skd_vld_q <= 1'b0;
		end else begin
			if (!res_vld_q || pop) begin
				if (skd_vld_q) begin
					res_vld_q <= 1'b1;
					skd_vld_q <= accept;
				end else begin
					res_vld_q <= accept;
				end
			end else if (accept) begin
				skd_vld_q <= 1'b1;
			end
		end
	end

	// payload, no reset needed
	always_ff @(posedge clk) begin
		if (!res_vld_q || pop) begin
			if (skd_vld_q) begin
				res_q <= skd_q;
				if (accept) begin
					skd_q <= res_d;
				end
			end else if (accept) begin
				res_q <= res_d;
			end
		end else if (accept) begin
			skd_q <= res_d;
		end
	end

`ifndef NO_ASSERTIONS
	// the skid entry never holds a result ahead of an empty output register
	a_skid_order: assert property (@(posedge clk) disable iff (!arst_n)
		skd_vld_q |-> res_vld_q)
		else $error("skid entry valid with output register empty");

	// a reporting channel is latched in the same result
	a_report_latched: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ((result.report_bits & ~result.latched_bits) == 4'd0))
		else $error("reported channel not latched");

	// siren-on only comes with a report
	a_siren_on_report: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.siren_on) |-> (result.report_bits != 4'd0))
		else $error("siren on without any report");

	// an idle siren timer carries no stale quiet count
	a_timer_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(trig_total_q == 8'd0) |-> (quiet_q == 8'd0 && last_seen_q == 8'd0))
		else $error("siren timer state left over while idle");
`endif

endmodule
